// File: sv/flfr_pkg.sv
// Shared constants and types for the fixed-length frame receiver.
package flfr_pkg;

  localparam int FRAME_LEN = 16;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int PADDR_W   = 3;

  localparam logic REG_HEADER  = 1'b0;
  localparam logic REG_TRAILER = 1'b1;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef logic [CNT_W-1:0] idx_t;

endpackage

// File: sv/fixed_length_frame_receiver_top.sv
// Fixed-length frame receiver: header/trailer check, frame store, replay.
// in_ready stays high while no replay runs. A release of a held frame moves
// the control state to replay, which starts reads; each byte passes the read
// register and then the output register to out_valid, one byte per cycle as
// out_ready allows. in_ready is low while the store is read.
// rst_n (synchronous) clears count, hold, control state and both word registers.
module fixed_length_frame_receiver_top
  import flfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_frame_byte,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic {ST_IDLE, ST_REPLAY} state_t;

  state_t      state_r, state_nxt;
  logic [15:0] header_r, trailer_r;
  idx_t        byte_count_r, byte_count_nxt;
  logic        frame_held_r, frame_held_nxt;
  logic [7:0]  trail_hi_r, trail_hi_nxt;
  idx_t        rd_idx_r, rd_idx_nxt;
  logic        rdv_r, rdv_nxt;
  logic        rd_last_r;
  logic [7:0]  rd_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_frame_byte_r;
  logic        out_last_r;

  logic [7:0]  frame_mem [FRAME_LEN];

  logic        in_xfer, cfg_wr, move, rd_en, wr_en;
  idx_t        wr_addr;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_TRAILER) ? {16'd0, trailer_r} : {16'd0, header_r};

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign move      = rdv_r && (!out_valid_r || out_ready);
  assign rd_en     = (state_r == ST_REPLAY) && (!rdv_r || move);

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_last       = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    byte_count_nxt = byte_count_r;
    frame_held_nxt = frame_held_r;
    trail_hi_nxt   = trail_hi_r;
    rd_idx_nxt     = rd_idx_r;
    wr_en          = 1'b0;
    wr_addr        = byte_count_r;
    if (in_xfer) begin
      if (in_kind == KIND_RELEASE) begin
        if (frame_held_r) begin
          frame_held_nxt = 1'b0;
          rd_idx_nxt     = '0;
          state_nxt      = ST_REPLAY;
        end
      end else if (!frame_held_r) begin
        if (byte_count_r == idx_t'(0)) begin
          if (in_rx_byte == header_r[15:8]) begin
            wr_en          = 1'b1;
            byte_count_nxt = idx_t'(1);
          end
        end else if (byte_count_r == idx_t'(1)) begin
          if (in_rx_byte == header_r[7:0]) begin
            wr_en          = 1'b1;
            byte_count_nxt = idx_t'(2);
          end
        end else begin
          wr_en = 1'b1;
          if (byte_count_r == idx_t'(FRAME_LEN - 2)) begin
            trail_hi_nxt = in_rx_byte;
          end
          if (byte_count_r == idx_t'(FRAME_LEN - 1)) begin
            byte_count_nxt = '0;
            frame_held_nxt = (trail_hi_r == trailer_r[15:8]) &&
                             (in_rx_byte == trailer_r[7:0]);
          end else begin
            byte_count_nxt = byte_count_r + idx_t'(1);
          end
        end
      end
    end
    if (rd_en) begin
      rd_idx_nxt = rd_idx_r + idx_t'(1);
      if (rd_idx_r == idx_t'(FRAME_LEN - 1)) begin
        state_nxt = ST_IDLE;
      end
    end
    rdv_nxt = rd_en || (rdv_r && !move);
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      header_r     <= '0;
      trailer_r    <= '0;
      byte_count_r <= '0;
      frame_held_r <= 1'b0;
      rdv_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      frame_held_r <= frame_held_nxt;
      rdv_r        <= rdv_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr) begin
        case (paddr[2])
          REG_HEADER:  header_r  <= pwdata[15:0];
          REG_TRAILER: trailer_r <= pwdata[15:0];
          default:     header_r  <= header_r;
        endcase
      end
    end
    trail_hi_r <= trail_hi_nxt;
    rd_idx_r   <= rd_idx_nxt;
    if (move) begin
      out_frame_byte_r <= rd_data_r;
      out_last_r       <= rd_last_r;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= in_rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= frame_mem[rd_idx_r];
      rd_last_r <= (rd_idx_r == idx_t'(FRAME_LEN - 1));
    end
  end

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("frame store read and write in same cycle");

  a_held_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    frame_held_r |-> (byte_count_r == '0))
    else $error("frame held with partial count");

  a_replay_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLAY) |-> !frame_held_r)
    else $error("hold still set during replay");

  a_last_ends_replay: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && rd_idx_r == idx_t'(FRAME_LEN - 1)) |=> (state_r == ST_IDLE))
    else $error("replay did not end after last read");
`endif

endmodule
